/* design/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Field widths, command codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int PRIO_W       = 16;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_PULL = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture a result this cycle
        logic push;      // insert the incoming entry
        logic pull;      // remove the front entry
        logic rejected;  // push dropped on a full queue
        logic valid;     // pull removed an entry
    } spq_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
    } spq_status_t;

endpackage

/* design/spq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl: request controller of the sorted priority queue
// Decodes each request against the fill status and sequences the result strobe.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        action,
    input  spq_status_t status,
    output spq_cmd_t    cmd,
    output logic        busy,
    output logic        done
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_RESULT = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    // every request completes in the cycle it is taken, so never stall
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        cmd.load     = accept;
        cmd.push     = accept && (action == ACT_PUSH) && !status.full;
        cmd.pull     = accept && (action == ACT_PULL) && !status.empty;
        cmd.rejected = accept && (action == ACT_PUSH) && status.full;
        cmd.valid    = accept && (action == ACT_PULL) && !status.empty;
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = accept ? ST_RESULT : ST_IDLE;
            ST_RESULT: state_next = accept ? ST_RESULT : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign done = (state_reg == ST_RESULT);

endmodule

/* design/spq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath: sorted shift chain and result registers
// Each slot compares its priority with the incoming one and either holds,
// takes the new entry, or takes its neighbour.
// ----------------------------------------------------------------------------
module spq_datapath
    import spq_pkg::*;
#(
    parameter int CAPACITY = SPQ_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  spq_cmd_t                 cmd,
    input  logic        [DATA_W-1:0] item_data,
    input  logic signed [PRIO_W-1:0] item_priority,
    output spq_status_t              status,
    output logic        [DATA_W-1:0] pulled_data,
    output logic                     pulled_valid,
    output logic                     push_rejected,
    output logic        [CNT_W-1:0]  entry_count
);

    logic        [DATA_W-1:0] data_reg  [CAPACITY];
    logic signed [PRIO_W-1:0] prio_reg  [CAPACITY];
    logic        [DATA_W-1:0] data_next [CAPACITY];
    logic signed [PRIO_W-1:0] prio_next [CAPACITY];

    logic [CAPACITY-1:0] gt;       // slot holds an entry that leaves after the new one
    logic [CAPACITY-1:0] at_end;   // first free slot
    logic [CAPACITY-1:0] prev_gt;

    logic        [DATA_W-1:0] prev_data [CAPACITY];
    logic signed [PRIO_W-1:0] prev_prio [CAPACITY];
    logic        [DATA_W-1:0] succ_data [CAPACITY];
    logic signed [PRIO_W-1:0] succ_prio [CAPACITY];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [DATA_W-1:0] res_data_reg;
    logic              res_valid_reg;
    logic              res_rej_reg;
    logic [CNT_W-1:0]  res_count_reg;

    assign status.full  = (count_reg == CNT_W'(CAPACITY));
    assign status.empty = (count_reg == '0);

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_slot
            assign gt[i]     = (CNT_W'(i) < count_reg) && (prio_reg[i] > item_priority);
            assign at_end[i] = (CNT_W'(i) == count_reg);

            if (i == 0)
            begin : g_head
                assign prev_gt[i]   = 1'b0;
                assign prev_data[i] = data_reg[i];
                assign prev_prio[i] = prio_reg[i];
            end
            else
            begin : g_body
                assign prev_gt[i]   = gt[i-1];
                assign prev_data[i] = data_reg[i-1];
                assign prev_prio[i] = prio_reg[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign succ_data[i] = data_reg[i];
                assign succ_prio[i] = prio_reg[i];
            end
            else
            begin : g_inner
                assign succ_data[i] = data_reg[i+1];
                assign succ_prio[i] = prio_reg[i+1];
            end

            always_comb
            begin
                data_next[i] = data_reg[i];
                prio_next[i] = prio_reg[i];
                if (cmd.push)
                begin
                    // later entries move back one slot; the new one lands at the gap
                    if (prev_gt[i])
                    begin
                        data_next[i] = prev_data[i];
                        prio_next[i] = prev_prio[i];
                    end
                    else if (gt[i] || at_end[i])
                    begin
                        data_next[i] = item_data;
                        prio_next[i] = item_priority;
                    end
                end
                else if (cmd.pull)
                begin
                    data_next[i] = succ_data[i];
                    prio_next[i] = succ_prio[i];
                end
            end

            always_ff @(posedge clk)
            begin
                data_reg[i] <= data_next[i];
                prio_reg[i] <= prio_next[i];
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pull)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_data_reg  <= cmd.valid ? data_reg[0] : '0;
            res_valid_reg <= cmd.valid;
            res_rej_reg   <= cmd.rejected;
            res_count_reg <= count_next;
        end
    end

    assign pulled_data   = res_data_reg;
    assign pulled_valid  = res_valid_reg;
    assign push_rejected = res_rej_reg;
    assign entry_count   = res_count_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_push_grows : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not add one entry");

    a_pull_shrinks : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pull |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pull did not remove one entry");

    a_front_sorted : assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> prio_reg[0] <= prio_reg[1])
        else $error("front entries out of order");

endmodule

/* design/sorted_priority_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: bounded sorted priority queue
// Push inserts in priority order (ties in arrival order); pull removes the
// entry with the smallest priority number. Every request returns one result.
//
//   channel   handshake        fields
//   request   start / busy     action, item_data, item_priority
//   result    done (strobe)    pulled_data, pulled_valid, push_rejected,
//                              entry_count
//
// One request per cycle: a request taken at an edge updates the whole shift
// chain at that edge, and its result shows on the next cycle with done high.
// The compare-and-shift across the CAPACITY slots sets the cycle time.
// busy stays low; results cannot be held off and last one cycle each.
// Reset empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY = SPQ_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     action,
    input  logic        [DATA_W-1:0] item_data,
    input  logic signed [PRIO_W-1:0] item_priority,
    output logic                     done,
    output logic        [DATA_W-1:0] pulled_data,
    output logic                     pulled_valid,
    output logic                     push_rejected,
    output logic        [CNT_W-1:0]  entry_count
);

    spq_cmd_t    cmd;
    spq_status_t status;

    spq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .item_data     (item_data),
        .item_priority (item_priority),
        .status        (status),
        .pulled_data   (pulled_data),
        .pulled_valid  (pulled_valid),
        .push_rejected (push_rejected),
        .entry_count   (entry_count)
    );

endmodule
